[rtl/cppl_pkg.sv]
package cppl_pkg;

    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    localparam logic [CNT_W-1:0] CNT_RESET = 7'd3;
    localparam logic [CNT_W-1:0] MIN_LEN   = 7'd3;

    // read address select
    localparam logic [1:0] RD_ZERO  = 2'd0;
    localparam logic [1:0] RD_MID   = 2'd1;
    localparam logic [1:0] RD_START = 2'd2;
    localparam logic [1:0] RD_NEXT  = 2'd3;

    // product pair operations
    localparam logic [1:0] OP_ORIENT = 2'd0;
    localparam logic [1:0] OP_E1     = 2'd1;
    localparam logic [1:0] OP_E2     = 2'd2;
    localparam logic [1:0] OP_E3     = 2'd3;

    typedef struct packed {
        logic       wr_en;
        logic       start_q;
        logic       cap_v0;
        logic       upd;
        logic       cap_a;
        logic       cap_b;
        logic       mul_en;
        logic [1:0] mul_op;
        logic       cap_s1;
        logic       cap_s2;
        logic       res_load;
        logic [1:0] rd_sel;
    } cmd_t;

    typedef struct packed {
        logic more;
    } stat_t;

endpackage

[rtl/cppl_if.sv]
interface cppl_req_if #(parameter int COORD_BITS = 12);
    import cppl_pkg::*;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [IDX_W-1:0]             vertex_index;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;

    modport source (output valid, output req_type, output vertex_index,
                    output x_coord, output y_coord, input ready);
    modport sink   (input valid, input req_type, input vertex_index,
                    input x_coord, input y_coord, output ready);
endinterface

interface cppl_res_if;
    import cppl_pkg::*;
    logic             valid;
    logic             ready;
    logic             inside_res;
    logic [IDX_W-1:0] wedge_index;

    modport source (output valid, output inside_res, output wedge_index, input ready);
    modport sink   (input valid, input inside_res, input wedge_index, output ready);
endinterface

interface cppl_cfg_if;
    import cppl_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] vertex_count;

    modport source (output valid, output vertex_count, input ready);
    modport sink   (input valid, input vertex_count, output ready);
endinterface

[rtl/convex_polygon_point_locator.sv]
// Query: from accept to result valid, the wedge search runs its halving steps
// (at most 6 for 64 vertices); each step is one vertex RAM read plus one cross
// product pass through the shared multiplier pair.
// Vertex writes are accepted back to back. A query blocks input until
// its result is loaded into the output register (held there if res stalls).
// Reset (rst_n, async low): idle, no result pending, vertex_count = 3.
module convex_polygon_point_locator #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    cppl_req_if.sink     req,
    cppl_res_if.source   res,
    cppl_cfg_if.sink     cfg
);
    import cppl_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg.ready = 1'b1;

    cppl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    cppl_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .vertex_index (req.vertex_index),
        .x_coord      (req.x_coord),
        .y_coord      (req.y_coord),
        .cfg_we       (cfg.valid),
        .cfg_count    (cfg.vertex_count),
        .inside_res   (res.inside_res),
        .wedge_index  (res.wedge_index)
    );
endmodule

[rtl/cppl_ram.sv]
module cppl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/cppl_ctrl.sv]
module cppl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_type,
    output logic          req_ready,
    output logic          res_valid,
    input  logic          res_ready,
    output cppl_pkg::cmd_t  cmd,
    input  cppl_pkg::stat_t stat
);
    import cppl_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CAP0 = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_EVAL = 4'd3;
    localparam logic [3:0] S_FA   = 4'd4;
    localparam logic [3:0] S_FB   = 4'd5;
    localparam logic [3:0] S_E2   = 4'd6;
    localparam logic [3:0] S_E3   = 4'd7;
    localparam logic [3:0] S_E4   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       res_valid_reg, res_valid_next;
    logic       accept;
    logic       res_free;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign res_free  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.wr_en   = accept && !req_type;
                cmd.start_q = accept && req_type;
                cmd.rd_sel  = RD_ZERO;
                if (accept && req_type)
                begin
                    state_next = S_CAP0;
                end
            end
            S_CAP0:
            begin
                cmd.cap_v0 = 1'b1;
                cmd.rd_sel = stat.more ? RD_MID : RD_START;
                state_next = stat.more ? S_MUL : S_FA;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = OP_ORIENT;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.upd    = 1'b1;
                cmd.rd_sel = stat.more ? RD_MID : RD_START;
                state_next = stat.more ? S_MUL : S_FA;
            end
            S_FA:
            begin
                cmd.cap_a  = 1'b1;
                cmd.rd_sel = RD_NEXT;
                state_next = S_FB;
            end
            S_FB:
            begin
                cmd.cap_b  = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.mul_op = OP_E1;
                state_next = S_E2;
            end
            S_E2:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = OP_E2;
                cmd.cap_s1 = 1'b1;
                state_next = S_E3;
            end
            S_E3:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = OP_E3;
                cmd.cap_s2 = 1'b1;
                state_next = S_E4;
            end
            S_E4:
            begin
                // hold here while the previous word is still unread
                if (res_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end
endmodule

[rtl/cppl_dp.sv]
module cppl_dp #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cppl_pkg::cmd_t                       cmd,
    output cppl_pkg::stat_t                      stat,
    input  logic [cppl_pkg::IDX_W-1:0]           vertex_index,
    input  logic signed [COORD_BITS-1:0]         x_coord,
    input  logic signed [COORD_BITS-1:0]         y_coord,
    input  logic                                 cfg_we,
    input  logic [cppl_pkg::CNT_W-1:0]           cfg_count,
    output logic                                 inside_res,
    output logic [cppl_pkg::IDX_W-1:0]           wedge_index
);
    import cppl_pkg::*;

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int CNT_MAX = (2 ** CNT_W) - 1;
    localparam logic [CNT_W-1:0] MAX_LEN =
        (MAX_VERTICES > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(MAX_VERTICES);

    logic [CNT_W-1:0]        count_reg;
    logic [IW-1:0]           start_reg, start_next;
    logic [CNT_W-1:0]        len_reg, len_next, len_init, half;
    logic signed [CW-1:0]    px_reg, py_reg, v0x_reg, v0y_reg;
    logic signed [CW-1:0]    ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [PW-1:0]    p1_reg, p2_reg, prod1, prod2;
    logic                    s1_reg, s2_reg, inside_reg;
    logic [IDX_W-1:0]        wedge_reg;
    logic                    gt, lt;
    logic                    ram_we;
    logic [IW-1:0]           raddr;
    logic [2*CW-1:0]         rdata;
    logic signed [CW-1:0]    rx, ry;
    logic signed [CW-1:0]    q1x, q1y, q2x, q2y, q3x, q3y;
    logic signed [DW-1:0]    d1, d2, d3, d4;

    function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] v);
        return {v[CW-1], v};
    endfunction

    assign ram_we = cmd.wr_en && (int'(vertex_index) < MAX_VERTICES);

    cppl_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IW'(vertex_index)),
        .wdata ({x_coord, y_coord}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rx = rdata[2*CW-1:CW];
    assign ry = rdata[CW-1:0];

    // products compare directly: orient > 0 and edge sign < 0 need no subtract
    assign gt = p1_reg > p2_reg;
    assign lt = p1_reg < p2_reg;

    always_comb
    begin
        if (count_reg < MIN_LEN)
        begin
            len_init = MIN_LEN;
        end
        else if (count_reg > MAX_LEN)
        begin
            len_init = MAX_LEN;
        end
        else
        begin
            len_init = count_reg;
        end
    end

    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        half       = len_reg >> 1;
        if (cmd.start_q)
        begin
            start_next = '0;
            len_next   = len_init;
        end
        else if (cmd.upd)
        begin
            if (gt)
            begin
                len_next = half + CNT_W'(1);
            end
            else
            begin
                start_next = start_reg + IW'(half);
                len_next   = len_reg - half;
            end
        end
    end

    assign stat.more = (len_next >= MIN_LEN);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_ZERO:  raddr = '0;
            RD_MID:   raddr = start_next + IW'(len_next >> 1);
            RD_START: raddr = start_next;
            RD_NEXT:  raddr = start_reg + IW'(1);
            default:  raddr = '0;
        endcase
    end

    always_comb
    begin
        q1x = px_reg;
        q1y = py_reg;
        q2x = v0x_reg;
        q2y = v0y_reg;
        q3x = ax_reg;
        q3y = ay_reg;
        unique case (cmd.mul_op)
            OP_ORIENT:
            begin
                q1x = v0x_reg;
                q1y = v0y_reg;
                q2x = rx;
                q2y = ry;
                q3x = px_reg;
                q3y = py_reg;
            end
            OP_E1:
            begin
                q2x = v0x_reg;
                q2y = v0y_reg;
                q3x = ax_reg;
                q3y = ay_reg;
            end
            OP_E2:
            begin
                q2x = ax_reg;
                q2y = ay_reg;
                q3x = bx_reg;
                q3y = by_reg;
            end
            OP_E3:
            begin
                q2x = bx_reg;
                q2y = by_reg;
                q3x = v0x_reg;
                q3y = v0y_reg;
            end
            default:
            begin
                q1x = px_reg;
            end
        endcase

        if (cmd.mul_op == OP_ORIENT)
        begin
            d1 = sx(q2y) - sx(q1y);
            d2 = sx(q3x) - sx(q2x);
            d3 = sx(q2x) - sx(q1x);
            d4 = sx(q3y) - sx(q2y);
        end
        else
        begin
            d1 = sx(q1x) - sx(q3x);
            d2 = sx(q2y) - sx(q3y);
            d3 = sx(q2x) - sx(q3x);
            d4 = sx(q1y) - sx(q3y);
        end
    end

    assign prod1 = d1 * d2;
    assign prod2 = d3 * d4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_RESET;
            start_reg <= '0;
            len_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_count;
            end
            start_reg <= start_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_q)
        begin
            px_reg <= x_coord;
            py_reg <= y_coord;
        end
        if (cmd.cap_v0)
        begin
            v0x_reg <= rx;
            v0y_reg <= ry;
        end
        if (cmd.cap_a)
        begin
            ax_reg <= rx;
            ay_reg <= ry;
        end
        if (cmd.cap_b)
        begin
            bx_reg <= rx;
            by_reg <= ry;
        end
        if (cmd.mul_en)
        begin
            p1_reg <= prod1;
            p2_reg <= prod2;
        end
        if (cmd.cap_s1)
        begin
            s1_reg <= lt;
        end
        if (cmd.cap_s2)
        begin
            s2_reg <= lt;
        end
        if (cmd.res_load)
        begin
            inside_reg <= (s1_reg == s2_reg) && (s2_reg == lt);
            wedge_reg  <= IDX_W'(start_reg);
        end
    end

    assign inside_res  = inside_reg;
    assign wedge_index = wedge_reg;
endmodule

[rtl/cppl_chk.sv]
module cppl_chk #(
    parameter int MAX_VERTICES = 64
) (
    input logic        clk,
    input logic        rst_n,
    cppl_req_if.sink   req,
    cppl_res_if.source res
);
    // a query holds off the next word
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.req_type |=> !req.ready)
        else $error("input ready right after a query was taken");

    // final range start leaves room for its second vertex
    a_wedge_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (MAX_VERTICES > 64) || (int'(res.wedge_index) <= MAX_VERTICES - 2))
        else $error("wedge index past the vertex table");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> $stable(res.inside_res) && $stable(res.wedge_index))
        else $error("result changed while stalled");
endmodule

bind convex_polygon_point_locator cppl_chk #(
    .MAX_VERTICES (MAX_VERTICES)
) u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res)
);

[tb/sv/convex_polygon_point_locator_checker.sv]
`timescale 1ns / 1ps

package cppl_tb_pkg;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } req_kind_e;

endpackage

module convex_polygon_point_locator_checker
    import cppl_pkg::*;
    import cppl_tb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cppl_req_if  req,
    cppl_res_if  res,
    cppl_cfg_if  cfg,
    output int   fail_count,
    output int   pending_count
);

    localparam int TABLE_DEPTH = 64;

    typedef struct {
        longint x;
        longint y;
    } point_t;

    typedef struct {
        logic             inside_res;
        logic [IDX_W-1:0] wedge_index;
    } locate_t;

    point_t           vertex_tab [TABLE_DEPTH];
    logic [CNT_W-1:0] vertex_count_q;
    locate_t          locate_q [$];
    int               errors = 0;

    function automatic longint wedge_turn(point_t a, point_t b, point_t c);
        return (b.y - a.y) * (c.x - b.x) - (b.x - a.x) * (c.y - b.y);
    endfunction

    function automatic longint edge_turn(point_t a, point_t b, point_t c);
        return (a.x - c.x) * (b.y - c.y) - (b.x - c.x) * (a.y - c.y);
    endfunction

    // binary search over the fan around vertex 0, then the triangle sign test
    function automatic locate_t locate_point(point_t p);
        int     span;
        int     first;
        int     half;
        point_t v0;
        point_t a;
        point_t b;
        bit     s1;
        bit     s2;
        bit     s3;
        locate_t r;
        span = int'(vertex_count_q);
        if (span < 3)
            span = 3;
        if (span > TABLE_DEPTH)
            span = TABLE_DEPTH;
        first = 0;
        v0 = vertex_tab[0];
        while (span >= 3)
        begin
            half = span / 2;
            if (wedge_turn(v0, vertex_tab[first + half], p) > 0)
                span = half + 1;
            else
            begin
                // collinear falls through to the upper half
                first = first + half;
                span  = span - half;
            end
        end
        a  = vertex_tab[first];
        b  = vertex_tab[first + 1];
        s1 = edge_turn(p, v0, a) < 0;
        s2 = edge_turn(p, a, b) < 0;
        s3 = edge_turn(p, b, v0) < 0;
        r.inside_res  = (s1 == s2) && (s2 == s3);
        r.wedge_index = first[IDX_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        point_t  p;
        locate_t want;
        if (!rst_n)
        begin
            vertex_count_q = CNT_RESET;
            locate_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                vertex_count_q = cfg.vertex_count;
            if (req.valid && req.ready)
            begin
                p.x = req.x_coord;
                p.y = req.y_coord;
                if (req.req_type == REQ_WRITE)
                    vertex_tab[req.vertex_index] = p;
                else
                    locate_q.push_back(locate_point(p));
            end
            if (res.valid && res.ready)
            begin
                if (locate_q.size() == 0)
                begin
                    $error("unexpected result word: inside_res %0d wedge_index %0d",
                           res.inside_res, res.wedge_index);
                    errors++;
                end
                else
                begin
                    want = locate_q.pop_front();
                    if (res.inside_res !== want.inside_res)
                    begin
                        $error("inside_res mismatch: expected %0d, actual %0d",
                               want.inside_res, res.inside_res);
                        errors++;
                    end
                    if (res.wedge_index !== want.wedge_index)
                    begin
                        $error("wedge_index mismatch: expected %0d, actual %0d",
                               want.wedge_index, res.wedge_index);
                        errors++;
                    end
                end
            end
        end
        pending_count <= locate_q.size();
        fail_count    <= errors;
    end

endmodule

[tb/sv/convex_polygon_point_locator_tb.sv]
`timescale 1ns / 1ps

module convex_polygon_point_locator_tb;

    import cppl_pkg::*;
    import cppl_tb_pkg::*;

    localparam int  MAX_VERTICES    = 64;
    localparam int  COORD_BITS      = 12;
    localparam int  STALL_LIMIT     = 5000;
    localparam int  DRAIN_CYCLES    = 40;
    localparam int  HOLD_CYCLES     = 400;
    localparam int  HOLD_PHASE      = 4;
    localparam int  QUERIES_PER_SET = 17;
    localparam int  COORD_MIN       = -2048;
    localparam int  COORD_MAX       = 2047;
    localparam real TWO_PI          = 6.283185307179586;

    logic clk = 1'b0;
    logic rst_n;

    cppl_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
    cppl_res_if res_bus ();
    cppl_cfg_if cfg_bus ();

    int fail_count;
    int pending_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asks      = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int poly_x [MAX_VERTICES];
    int poly_y [MAX_VERTICES];
    int poly_n;
    int count_plan [] = '{0, 2, 3, 4, 5, 7, 8, 16, 32, 33, 63, 64, 65, 127, -1};

    always #4 clk = ~clk;

    convex_polygon_point_locator #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    convex_polygon_point_locator_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_bus),
        .res           (res_bus),
        .cfg           (cfg_bus),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (holds_served != hold_asks)
        begin
            holds_served = hold_asks;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_bus.ready <= 1'b0;
        end
        else
            res_bus.ready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int clip(int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    task automatic send_word(input req_kind_e kind, input int idx, input int x, input int y);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= kind;
        req_bus.vertex_index <= idx[IDX_W-1:0];
        req_bus.x_coord      <= x[COORD_BITS-1:0];
        req_bus.y_coord      <= y[COORD_BITS-1:0];
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
    endtask

    // all results in, then let a trailing vertex write or query drain
    task automatic settle();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input int value);
        settle();
        cfg_bus.valid        <= 1'b1;
        cfg_bus.vertex_count <= value[CNT_W-1:0];
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // vertices on a circle at jittered, monotonic angles
    task automatic load_polygon(input int n);
        real radius;
        real base;
        real dir;
        real ang;
        int  span;
        int  cx;
        int  cy;
        poly_n = n;
        if (n <= 8 && $urandom_range(3) == 0)
            radius = $urandom_range(60, 4);
        else
            radius = $urandom_range(2040, 300);
        span = COORD_MAX - int'(radius);
        if (span < 0)
            span = 0;
        cx   = int'($urandom_range(2 * span)) - span;
        cy   = int'($urandom_range(2 * span)) - span;
        base = TWO_PI * $urandom_range(999) / 1000.0;
        dir  = ($urandom_range(1) == 1) ? 1.0 : -1.0;
        for (int k = 0; k < n; k++)
        begin
            ang = base + dir * TWO_PI * (k + 0.8 * $urandom_range(999) / 1000.0) / n;
            poly_x[k] = clip(cx + int'(radius * $cos(ang)));
            poly_y[k] = clip(cy + int'(radius * $sin(ang)));
            send_word(REQ_WRITE, k, poly_x[k], poly_y[k]);
        end
    endtask

    function automatic int corner_coord();
        case ($urandom_range(3))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    task automatic send_query();
        int pick;
        int k;
        int x;
        int y;
        int xmin;
        int xmax;
        int ymin;
        int ymax;
        pick = $urandom_range(99);
        k    = $urandom_range(poly_n - 1);
        if (pick < 45)
        begin
            xmin = poly_x[0];
            xmax = poly_x[0];
            ymin = poly_y[0];
            ymax = poly_y[0];
            for (int i = 1; i < poly_n; i++)
            begin
                xmin = (poly_x[i] < xmin) ? poly_x[i] : xmin;
                xmax = (poly_x[i] > xmax) ? poly_x[i] : xmax;
                ymin = (poly_y[i] < ymin) ? poly_y[i] : ymin;
                ymax = (poly_y[i] > ymax) ? poly_y[i] : ymax;
            end
            x = xmin - 5 + int'($urandom_range(xmax - xmin + 10));
            y = ymin - 5 + int'($urandom_range(ymax - ymin + 10));
        end
        else if (pick < 60)
        begin
            x = poly_x[k];
            y = poly_y[k];
        end
        else if (pick < 70)
        begin
            // edge midpoint, on the boundary when the sum is even
            x = (poly_x[k] + poly_x[(k + 1) % poly_n]) / 2;
            y = (poly_y[k] + poly_y[(k + 1) % poly_n]) / 2;
        end
        else if (pick < 80)
        begin
            x = int'($urandom_range(4095)) + COORD_MIN;
            y = int'($urandom_range(4095)) + COORD_MIN;
        end
        else if (pick < 88)
        begin
            x = corner_coord();
            y = corner_coord();
        end
        else
        begin
            x = poly_x[0] + int'($urandom_range(6)) - 3;
            y = poly_y[0] + int'($urandom_range(6)) - 3;
        end
        send_word(REQ_QUERY, $urandom_range(63), clip(x), clip(y));
    endtask

    initial
    begin
        int used;
        int value;
        rst_n                = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.req_type     = REQ_WRITE;
        req_bus.vertex_index = '0;
        req_bus.x_coord      = '0;
        req_bus.y_coord      = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.vertex_count = '0;
        res_bus.ready        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset count of 3: full-range triangle
        send_word(REQ_WRITE, 0, COORD_MIN, COORD_MIN);
        send_word(REQ_WRITE, 1, COORD_MAX, COORD_MIN);
        send_word(REQ_WRITE, 2, 0, COORD_MAX);
        send_word(REQ_QUERY, 0, 0, 0);
        send_word(REQ_QUERY, 63, COORD_MAX, COORD_MAX);
        send_word(REQ_QUERY, 0, COORD_MIN, COORD_MIN);
        send_word(REQ_QUERY, 21, COORD_MIN, COORD_MAX);
        send_word(REQ_QUERY, 42, COORD_MAX, COORD_MIN);
        send_word(REQ_QUERY, 0, 0, COORD_MIN);
        send_word(REQ_QUERY, 0, -1, -1);
        // degenerate triangle, every sign zero at the point itself
        send_word(REQ_WRITE, 0, 5, 5);
        send_word(REQ_WRITE, 1, 5, 5);
        send_word(REQ_WRITE, 2, 5, 5);
        send_word(REQ_QUERY, 0, 5, 5);
        send_word(REQ_QUERY, 0, 6, 5);
        // collinear vertices, zero orientation on the search step
        send_word(REQ_WRITE, 0, 0, 0);
        send_word(REQ_WRITE, 1, 10, 10);
        send_word(REQ_WRITE, 2, 20, 20);
        send_word(REQ_QUERY, 0, 30, 30);
        send_word(REQ_QUERY, 0, 15, 15);
        send_word(REQ_QUERY, 0, -5, -5);
        send_word(REQ_QUERY, 0, 15, 16);

        for (int ph = 0; ph < count_plan.size(); ph++)
        begin
            case (ph % 5)
                1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
                3:       begin send_idle_pct = 17; recv_stall_pct = 17; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            value = (count_plan[ph] < 0) ? int'($urandom_range(127)) : count_plan[ph];
            write_count(value);
            used = (value < 3) ? 3 : ((value > MAX_VERTICES) ? MAX_VERTICES : value);
            load_polygon(used);
            if (ph == HOLD_PHASE)
                hold_asks++;
            for (int q = 0; q < QUERIES_PER_SET; q++)
            begin
                // occasional stray vertex overwrite breaks convexity
                if ($urandom_range(99) < 6)
                begin
                    value = $urandom_range(used - 1);
                    poly_x[value] = int'($urandom_range(4095)) + COORD_MIN;
                    poly_y[value] = int'($urandom_range(4095)) + COORD_MIN;
                    send_word(REQ_WRITE, value, poly_x[value], poly_y[value]);
                end
                send_query();
            end
        end

        settle();
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
